/* hw/rtl/xtea_pkg.sv */
// Shared types, constants and round helpers for the XTEA block cipher.
// Depends on nothing; every other file in hw/rtl imports it.
package xtea_pkg;

   localparam int unsigned NUM_CYCLES_DEF = 32;
   localparam int unsigned WORD_W         = 32;
   localparam int unsigned CSR_ADDR_W     = 4;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam logic [WORD_W-1:0] DELTA    = 32'h9E37_79B9;

   typedef enum logic {
      ACT_ENCRYPT = 1'b0,
      ACT_DECRYPT = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      REG_KEY_WORD0 = 2'd0,
      REG_KEY_WORD1 = 2'd1,
      REG_KEY_WORD2 = 2'd2,
      REG_KEY_WORD3 = 2'd3
   } reg_index_type;

   typedef struct packed {
      action_type        action;
      logic [WORD_W-1:0] block_left;
      logic [WORD_W-1:0] block_right;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_left;
      logic [WORD_W-1:0] out_right;
   } rsp_type;

   // block in flight between two pipeline stages
   typedef struct packed {
      action_type        action;
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } lane_type;

   typedef logic [3:0][WORD_W-1:0] key_type;

   function automatic logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   // running sum after k additions of DELTA, modulo 2^32
   function automatic logic [WORD_W-1:0] sum_after(int unsigned k);
      logic [WORD_W-1:0] kk;
      kk = WORD_W'(k);
      return WORD_W'(DELTA * kk);
   endfunction

endpackage

/* hw/rtl/xtea_csr.sv */
// APB-style key register file: four 32-bit key words, reset to zero.
// Depends on xtea_pkg.
module xtea_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [xtea_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [xtea_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [xtea_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output xtea_pkg::key_type                key
);
   import xtea_pkg::*;

   key_type       key_ff, key_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_KEY_WORD0: key_in[0] = pwdata;
            REG_KEY_WORD1: key_in[1] = pwdata;
            REG_KEY_WORD2: key_in[2] = pwdata;
            REG_KEY_WORD3: key_in[3] = pwdata;
            default:       key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign prdata = key_ff[reg_idx];
   assign key    = key_ff;

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> key_ff[$past(paddr[3:2])] == $past(pwdata))
      else $error("key write not stored");

endmodule

/* hw/rtl/xtea_round_stage.sv */
// One pipeline stage of the XTEA datapath: a single Feistel half-round.
// Depends on xtea_pkg; instantiated 2*NUM_CYCLES times by the top level.
module xtea_round_stage #(
   parameter int unsigned STAGE      = 0,
   parameter int unsigned NUM_CYCLES = xtea_pkg::NUM_CYCLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  xtea_pkg::lane_type in_lane,
   input  xtea_pkg::key_type  key,
   output logic               out_valid,
   output xtea_pkg::lane_type out_lane
);
   import xtea_pkg::*;

   localparam int unsigned ROUND = STAGE / 2;
   localparam int unsigned HALF  = STAGE % 2;
   // encrypt walks the sum up from zero, decrypt walks it down from the top
   localparam logic [WORD_W-1:0] ENC_SUM =
      (HALF == 0) ? sum_after(ROUND) : sum_after(ROUND + 1);
   localparam logic [WORD_W-1:0] DEC_SUM =
      (HALF == 0) ? sum_after(NUM_CYCLES - ROUND) : sum_after(NUM_CYCLES - ROUND - 1);
   localparam logic ENC_LEFT = (HALF == 0);

   logic              is_dec;
   logic              upd_left;
   logic [WORD_W-1:0] sum;
   logic [1:0]        key_idx;
   logic [WORD_W-1:0] src_word, dst_word, f_word, new_word;

   logic     valid_ff, valid_in;
   lane_type lane_ff, lane_in;

   always_comb begin
      is_dec   = (in_lane.action == ACT_DECRYPT);
      upd_left = is_dec ? !ENC_LEFT : ENC_LEFT;
      sum      = is_dec ? DEC_SUM : ENC_SUM;
      key_idx  = upd_left ? sum[1:0] : sum[12:11];
      src_word = upd_left ? in_lane.right : in_lane.left;
      dst_word = upd_left ? in_lane.left : in_lane.right;
      f_word   = mix_word(src_word) ^ (sum + key[key_idx]);
      new_word = is_dec ? (dst_word - f_word) : (dst_word + f_word);

      lane_in        = in_lane;
      if (upd_left) begin
         lane_in.left = new_word;
      end else begin
         lane_in.right = new_word;
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

   a_valid_follows: assert property (@(posedge clock) disable iff (reset)
      valid_ff == $past(in_valid && !reset))
      else $error("stage valid lost or invented");

   a_action_kept: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> lane_ff.action == $past(in_lane.action))
      else $error("action bit changed in stage");

   a_other_half_kept: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ($past(upd_left) ? lane_ff.right == $past(in_lane.right)
                                    : lane_ff.left == $past(in_lane.left)))
      else $error("untouched half of block changed");

endmodule

/* hw/rtl/xtea_block_cipher.sv */
// XTEA block cipher, top level: key registers plus the unrolled round pipeline.
// Depends on xtea_pkg, xtea_csr and xtea_round_stage.
//
// One 64-bit block enters on every clock at which start is high (busy is always
// low), and its result leaves on rsp_data with a one-cycle rsp_valid strobe
// once it has passed through every register stage of the chain, in order.
// Throughput is one block per clock for any mix of encrypt and decrypt. The
// datapath is a chain of 2*NUM_CYCLES register stages, one Feistel half-round
// each; a stage's depth is the mix add followed by the accumulate add or
// subtract, which sets the clock. Results cannot be held off, and none need
// be: the pipeline never stalls. The 128-bit key sits in four APB registers at
// byte addresses 0x0, 0x4, 0x8 and 0xC, reset to zero; rewrite it only when no
// transfer is in flight, since every stage reads the live key words.
module xtea_block_cipher #(
   parameter int unsigned NUM_CYCLES = xtea_pkg::NUM_CYCLES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // block input, command style
   input  logic                             start,
   output logic                             busy,
   input  xtea_pkg::req_type                req_data,
   // result strobe
   output logic                             rsp_valid,
   output xtea_pkg::rsp_type                rsp_data,
   // key registers
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [xtea_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [xtea_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [xtea_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import xtea_pkg::*;

   localparam int unsigned STAGES = 2 * NUM_CYCLES;

   key_type  key;
   logic     stage_valid [0:STAGES];
   lane_type stage_lane  [0:STAGES];

   // a fully pipelined datapath takes a block every clock
   assign busy = 1'b0;

   xtea_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   // stage 0 input comes straight from the ports
   assign stage_valid[0]       = start && !busy;
   assign stage_lane[0].action = req_data.action;
   assign stage_lane[0].left   = req_data.block_left;
   assign stage_lane[0].right  = req_data.block_right;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      xtea_round_stage #(
         .STAGE      (s),
         .NUM_CYCLES (NUM_CYCLES)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_lane   (stage_lane[s]),
         .key       (key),
         .out_valid (stage_valid[s+1]),
         .out_lane  (stage_lane[s+1])
      );
   end

   // last stage register drives the result ports directly
   assign rsp_valid          = stage_valid[STAGES];
   assign rsp_data.out_left  = stage_lane[STAGES].left;
   assign rsp_data.out_right = stage_lane[STAGES].right;

endmodule
